>>> src/ima_pkg.sv
package ima_pkg;

  localparam int SampleWidth = 16;
  localparam int IndexWidth  = 7;
  localparam int CodeWidth   = 4;
  localparam int ByteWidth   = 8;

  localparam logic signed [17:0] PredMax  = 18'sd32767;
  localparam logic signed [17:0] PredMin  = -18'sd32768;
  localparam logic [IndexWidth-1:0] IndexMax = 7'd88;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [IndexWidth-1:0] index_t;
  typedef logic [CodeWidth-1:0] code_t;
  typedef logic [ByteWidth-1:0] byte_t;
  typedef logic [15:0] step_t;

  // Step size table; indexes past the top entry (87) read 32767.
  function automatic step_t step_rom(input index_t idx);
    step_t s;
    case (idx)
      7'd0:  s = 16'd7;     7'd1:  s = 16'd8;     7'd2:  s = 16'd9;
      7'd3:  s = 16'd10;    7'd4:  s = 16'd11;    7'd5:  s = 16'd12;
      7'd6:  s = 16'd13;    7'd7:  s = 16'd14;    7'd8:  s = 16'd16;
      7'd9:  s = 16'd17;    7'd10: s = 16'd19;    7'd11: s = 16'd21;
      7'd12: s = 16'd23;    7'd13: s = 16'd25;    7'd14: s = 16'd28;
      7'd15: s = 16'd31;    7'd16: s = 16'd34;    7'd17: s = 16'd37;
      7'd18: s = 16'd41;    7'd19: s = 16'd45;    7'd20: s = 16'd50;
      7'd21: s = 16'd55;    7'd22: s = 16'd60;    7'd23: s = 16'd66;
      7'd24: s = 16'd73;    7'd25: s = 16'd80;    7'd26: s = 16'd88;
      7'd27: s = 16'd97;    7'd28: s = 16'd107;   7'd29: s = 16'd118;
      7'd30: s = 16'd130;   7'd31: s = 16'd143;   7'd32: s = 16'd157;
      7'd33: s = 16'd173;   7'd34: s = 16'd190;   7'd35: s = 16'd209;
      7'd36: s = 16'd230;   7'd37: s = 16'd253;   7'd38: s = 16'd279;
      7'd39: s = 16'd307;   7'd40: s = 16'd337;   7'd41: s = 16'd371;
      7'd42: s = 16'd408;   7'd43: s = 16'd449;   7'd44: s = 16'd494;
      7'd45: s = 16'd544;   7'd46: s = 16'd598;   7'd47: s = 16'd658;
      7'd48: s = 16'd724;   7'd49: s = 16'd796;   7'd50: s = 16'd876;
      7'd51: s = 16'd963;   7'd52: s = 16'd1060;  7'd53: s = 16'd1166;
      7'd54: s = 16'd1282;  7'd55: s = 16'd1411;  7'd56: s = 16'd1552;
      7'd57: s = 16'd1707;  7'd58: s = 16'd1878;  7'd59: s = 16'd2066;
      7'd60: s = 16'd2272;  7'd61: s = 16'd2499;  7'd62: s = 16'd2749;
      7'd63: s = 16'd3024;  7'd64: s = 16'd3327;  7'd65: s = 16'd3660;
      7'd66: s = 16'd4026;  7'd67: s = 16'd4428;  7'd68: s = 16'd4871;
      7'd69: s = 16'd5358;  7'd70: s = 16'd5894;  7'd71: s = 16'd6484;
      7'd72: s = 16'd7132;  7'd73: s = 16'd7845;  7'd74: s = 16'd8630;
      7'd75: s = 16'd9493;  7'd76: s = 16'd10442; 7'd77: s = 16'd11487;
      7'd78: s = 16'd12635; 7'd79: s = 16'd13899; 7'd80: s = 16'd15289;
      7'd81: s = 16'd16818; 7'd82: s = 16'd18500; 7'd83: s = 16'd20350;
      7'd84: s = 16'd22385; 7'd85: s = 16'd24623; 7'd86: s = 16'd27086;
      7'd87: s = 16'd29794;
      default: s = 16'd32767;
    endcase
    return s;
  endfunction

  // Index change for the 3-bit magnitude of a code.
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    case (mag)
      3'd4: a = 5'sd2;
      3'd5: a = 5'sd4;
      3'd6: a = 5'sd6;
      3'd7: a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

>>> src/ima_pcm_if.sv
interface ima_pcm_if import ima_pkg::*; ();
  logic valid;
  logic ready;
  sample_t sample;
  logic last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

>>> src/ima_byte_if.sv
interface ima_byte_if import ima_pkg::*; ();
  logic valid;
  logic ready;
  byte_t packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink (input valid, input packed_byte, output ready);
endinterface

>>> src/ima_adpcm_encoder_top.sv
// IMA ADPCM encoder: one 16-bit sample in, one 4-bit code out, two codes per byte.
// Path from sample accept to byte valid: input register, then result register.
// Throughput: one sample per cycle while the byte output is not stalled; the loop
// through predictor, step ROM and the three quantizer compares is combinational.
// Reset (rst, synchronous): predictor, step index, pending nibble and phase clear,
// both pipeline registers empty.
module ima_adpcm_encoder_top import ima_pkg::*; (
  input  logic clk,
  input  logic rst,
  ima_pcm_if.sink    pcm,
  ima_byte_if.source adpcm
);

  // input register
  logic    in_full;
  sample_t in_sample;
  logic    in_last;

  // encoder state
  logic signed [15:0] predicted_value;
  index_t             step_index;
  code_t              pending_nibble;
  logic               low_half_next;

  // result register
  logic  out_full;
  byte_t out_byte;

  logic out_free;
  logic fire;

  assign out_free = !out_full || adpcm.ready;
  assign fire     = in_full && out_free;
  assign pcm.ready = !in_full || fire;

  assign adpcm.valid       = out_full;
  assign adpcm.packed_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (pcm.ready) begin
      in_full <= pcm.valid;
    end
    if (pcm.valid && pcm.ready) begin
      in_sample <= pcm.sample;
      in_last   <= pcm.last_sample;
    end
  end

  // quantizer
  step_t              step;
  logic signed [17:0] diff;
  logic        [16:0] mag0, mag1, mag2;
  logic        [16:0] vp0, vp1, vp2, vpdiff;
  logic        [16:0] st0, st1, st2;
  logic               neg;
  logic        [2:0]  qmag;
  code_t              code;
  logic signed [17:0] pred_sum;
  logic signed [15:0] predicted_value_next;
  logic signed [8:0]  idx_sum;
  index_t             step_index_next;

  always_comb begin
    step = step_rom(step_index);
    diff = 18'(in_sample) - 18'(predicted_value);
    neg  = diff[17];
    mag0 = neg ? 17'(-diff) : 17'(diff);
    st0  = {1'b0, step};
    st1  = {2'b0, step[15:1]};
    st2  = {3'b0, step[15:2]};
    vp0  = {4'b0, step[15:3]};

    qmag[2] = mag0 >= st0;
    mag1    = qmag[2] ? mag0 - st0 : mag0;
    vp1     = qmag[2] ? vp0 + st0 : vp0;

    qmag[1] = mag1 >= st1;
    mag2    = qmag[1] ? mag1 - st1 : mag1;
    vp2     = qmag[1] ? vp1 + st1 : vp1;

    qmag[0] = mag2 >= st2;
    vpdiff  = qmag[0] ? vp2 + st2 : vp2;

    code = {neg, qmag};

    pred_sum = neg ? 18'(predicted_value) - 18'(signed'({1'b0, vpdiff}))
                   : 18'(predicted_value) + 18'(signed'({1'b0, vpdiff}));
    if (pred_sum > PredMax) begin
      predicted_value_next = 16'(PredMax);
    end else if (pred_sum < PredMin) begin
      predicted_value_next = 16'(PredMin);
    end else begin
      predicted_value_next = pred_sum[15:0];
    end

    idx_sum = signed'({2'b0, step_index}) + 9'(index_adjust(qmag));
    if (idx_sum < 0) begin
      step_index_next = '0;
    end else if (idx_sum > signed'({2'b0, IndexMax})) begin
      step_index_next = IndexMax;
    end else begin
      step_index_next = idx_sum[IndexWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predicted_value <= '0;
      step_index      <= '0;
      pending_nibble  <= '0;
      low_half_next   <= 1'b0;
      out_full        <= 1'b0;
    end else begin
      if (adpcm.ready) begin
        out_full <= 1'b0;
      end
      if (fire) begin
        if (low_half_next) begin
          out_full <= 1'b1;
        end
        if (in_last) begin
          // end of stream: drop any odd nibble and start over
          predicted_value <= '0;
          step_index      <= '0;
          pending_nibble  <= '0;
          low_half_next   <= 1'b0;
        end else begin
          predicted_value <= predicted_value_next;
          step_index      <= step_index_next;
          low_half_next   <= !low_half_next;
          if (!low_half_next) begin
            pending_nibble <= code;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && low_half_next) begin
      out_byte <= {pending_nibble, code};
    end
  end

endmodule
